FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/tnst_pkg.sv
package tnst_pkg;

  // fixed field widths
  localparam int unsigned CmdW  = 2;
  localparam int unsigned ValW  = 32;
  localparam int unsigned TagW  = 16;
  localparam int unsigned CfgW  = 4;

  // parameter defaults
  localparam int unsigned MaxEntriesDef = 8;
  localparam int unsigned TagBitsDef    = 16;

  // reset value of the kept-entry count
  localparam logic [CfgW-1:0] TopCountRst = 4'd5;

  // command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } tnst_state_e;

  // operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic clr;
    logic rot;
  } tnst_op_t;

  // status a cell shows its neighbors
  typedef struct packed {
    logic used;
    logic counted;
    logic gt;
  } tnst_flags_t;

endpackage

FILE: design/tnst_cell.sv
module tnst_cell import tnst_pkg::*; #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned CNT_W    = 4,
  parameter int unsigned TAG_BITS = TagBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tnst_op_t                   op_i,
  input  logic [CNT_W-1:0]           cap_i,
  input  logic signed [ValW-1:0]     new_value_i,
  input  logic [TAG_BITS-1:0]        new_tag_i,
  input  tnst_flags_t                left_flags_i,
  input  logic signed [ValW-1:0]     left_value_i,
  input  logic [TAG_BITS-1:0]        left_tag_i,
  input  logic                       right_used_i,
  input  logic signed [ValW-1:0]     right_value_i,
  input  logic [TAG_BITS-1:0]        right_tag_i,
  output tnst_flags_t                flags_o,
  output logic signed [ValW-1:0]     value_o,
  output logic [TAG_BITS-1:0]        tag_o
);

  logic                   used_q, used_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [TAG_BITS-1:0]    tag_q, tag_d;
  logic                   in_cap;

  // position within the active cap, and compare against the broadcast value
  assign in_cap          = CNT_W'(IDX) < cap_i;
  assign flags_o.used    = used_q;
  assign flags_o.counted = used_q && in_cap;
  assign flags_o.gt      = used_q && in_cap && (val_q > new_value_i);
  assign value_o         = val_q;
  assign tag_o           = tag_q;

  // keep, take the new beat, take the left neighbor, rotate or drop
  always_comb begin
    used_d = used_q;
    val_d  = val_q;
    tag_d  = tag_q;
    if (op_i.clr) begin
      used_d = 1'b0;
    end else if (op_i.rot) begin
      used_d = right_used_i;
      val_d  = right_value_i;
      tag_d  = right_tag_i;
    end else if (op_i.ins && !flags_o.gt) begin
      if (in_cap && left_flags_i.gt) begin
        used_d = 1'b1;
        val_d  = new_value_i;
        tag_d  = new_tag_i;
      end else if (in_cap && left_flags_i.counted) begin
        used_d = 1'b1;
        val_d  = left_value_i;
        tag_d  = left_tag_i;
      end else begin
        used_d = 1'b0;
      end
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    tag_q <= tag_d;
  end

endmodule

FILE: design/tnst_ctrl.sv
module tnst_ctrl import tnst_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned TAG_BITS    = TagBitsDef,
  parameter int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   head_used_i,
  input  logic                   next_used_i,
  input  logic signed [ValW-1:0] head_value_i,
  input  logic [TAG_BITS-1:0]    head_tag_i,
  output tnst_op_t               op_o,
  output logic [CNT_W-1:0]       cap_o,
  output logic                   out_strobe_o,
  output logic                   out_valid_o,
  output logic signed [ValW-1:0] out_value_o,
  output logic [TagW-1:0]        out_tag_o,
  output logic                   out_last_o
);

  localparam logic [CNT_W-1:0] KLast = CNT_W'(MAX_ENTRIES - 1);

  tnst_state_e            state_q, state_d;
  logic [CNT_W-1:0]       k_q, k_d;
  logic [CfgW-1:0]        top_count_q;
  logic                   accept;
  logic                   strobe_q, strobe_d;
  logic                   valid_q, valid_d;
  logic                   last_q, last_d;
  logic signed [ValW-1:0] value_q, value_d;
  logic [TagW-1:0]        tag_q, tag_d;

  assign busy         = (state_q != ST_IDLE);
  assign accept       = start && !busy;
  assign cfg_ready_o  = !busy;
  assign out_strobe_o = strobe_q;
  assign out_valid_o  = valid_q;
  assign out_value_o  = value_q;
  assign out_tag_o    = tag_q;
  assign out_last_o   = last_q;

  // saturate the configured count to one..MAX_ENTRIES
  always_comb begin
    if (top_count_q == '0) begin
      cap_o = CNT_W'(1);
    end else if (8'(top_count_q) > 8'(MAX_ENTRIES)) begin
      cap_o = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_o = CNT_W'(top_count_q);
    end
  end

  // command decode, read-out sequencing and result beat
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    op_o     = '0;
    strobe_d = 1'b0;
    valid_d  = 1'b0;
    last_d   = 1'b0;
    value_d  = '0;
    tag_d    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_INSERT: op_o.ins = 1'b1;
            CMD_CLEAR:  op_o.clr = 1'b1;
            CMD_READ: begin
              state_d = ST_READ;
              k_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // chain rotates one place a cycle, full turn restores the order
        op_o.rot = 1'b1;
        if (k_q == '0 && !head_used_i) begin
          strobe_d = 1'b1;
          last_d   = 1'b1;
        end else if (head_used_i && k_q < cap_o) begin
          strobe_d = 1'b1;
          valid_d  = 1'b1;
          value_d  = head_value_i;
          tag_d    = TagW'(head_tag_i);
          last_d   = (CNT_W'(k_q + 1'b1) == cap_o) || !next_used_i;
        end
        if (k_q == KLast) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      top_count_q <= TopCountRst;
      strobe_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        top_count_q <= cfg_data_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    valid_q <= valid_d;
    last_q  <= last_d;
    value_q <= value_d;
    tag_q   <= tag_d;
  end

endmodule

FILE: design/top_n_sorted_tracker_core.sv
// insert and clear are applied when accepted; busy stays low and the next command is taken next cycle
// read: busy while the cell chain makes one full rotation
// read results stream one per cycle, formed in the read state and registered before they leave
// throughput: one insert or clear per cycle while no read runs; no command is taken during a read
// reset empties the store and sets the kept-entry count to 5; results cannot be stalled
module top_n_sorted_tracker_core import tnst_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic signed [ValW-1:0] new_value_i,
  input  logic [TagW-1:0]        node_tag_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_data_i,
  output logic                   out_strobe_o,
  output logic                   out_valid_o,
  output logic signed [ValW-1:0] out_value_o,
  output logic [TagW-1:0]        out_tag_o,
  output logic                   out_last_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  tnst_op_t               op;
  logic [CntW-1:0]        cap;
  logic [TAG_BITS-1:0]    new_tag;
  logic                   next_used;
  tnst_flags_t            flags [MAX_ENTRIES];
  logic signed [ValW-1:0] vals  [MAX_ENTRIES];
  logic [TAG_BITS-1:0]    tags  [MAX_ENTRIES];

  // keep the low tag bits, or widen
  assign new_tag = TAG_BITS'(node_tag_i);

  // the cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    tnst_flags_t            left_flags;
    logic signed [ValW-1:0] left_value;
    logic [TAG_BITS-1:0]    left_tag;
    localparam int unsigned RightIdx = (i + 1) % MAX_ENTRIES;

    if (i == 0) begin : g_head
      // head sees a virtual larger neighbor, so it takes the new beat unless it holds a larger value itself
      assign left_flags = '{used: 1'b1, counted: 1'b1, gt: 1'b1};
      assign left_value = '0;
      assign left_tag   = '0;
    end else begin : g_body
      assign left_flags = flags[i-1];
      assign left_value = vals[i-1];
      assign left_tag   = tags[i-1];
    end

    tnst_cell #(
      .IDX      (i),
      .CNT_W    (CntW),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .cap_i         (cap),
      .new_value_i   (new_value_i),
      .new_tag_i     (new_tag),
      .left_flags_i  (left_flags),
      .left_value_i  (left_value),
      .left_tag_i    (left_tag),
      .right_used_i  (flags[RightIdx].used),
      .right_value_i (vals[RightIdx]),
      .right_tag_i   (tags[RightIdx]),
      .flags_o       (flags[i]),
      .value_o       (vals[i]),
      .tag_o         (tags[i])
    );
  end

  // occupancy of the entry behind the head
  if (MAX_ENTRIES > 1) begin : g_next
    assign next_used = flags[1].used;
  end else begin : g_no_next
    assign next_used = 1'b0;
  end

  tnst_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TAG_BITS    (TAG_BITS),
    .CNT_W       (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .head_used_i  (flags[0].used),
    .next_used_i  (next_used),
    .head_value_i (vals[0]),
    .head_tag_i   (tags[0]),
    .op_o         (op),
    .cap_o        (cap),
    .out_strobe_o (out_strobe_o),
    .out_valid_o  (out_valid_o),
    .out_value_o  (out_value_o),
    .out_tag_o    (out_tag_o),
    .out_last_o   (out_last_o)
  );

endmodule

FILE: design/tnst_checker.sv
`include "assert_macros.svh"

module tnst_checker import tnst_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic [CmdW-1:0]        cmd_i,
  input logic                   cfg_ready_o,
  input logic                   out_strobe_o,
  input logic                   out_valid_o,
  input logic signed [ValW-1:0] out_value_o,
  input logic [TagW-1:0]        out_tag_o,
  input logic                   out_last_o
);

  logic ins_acc;
  logic read_acc;
  logic empty_ok;

  assign ins_acc  = start && !busy && (cmd_i == CMD_INSERT);
  assign read_acc = start && !busy && (cmd_i == CMD_READ);
  assign empty_ok = out_last_o && (out_value_o == 0) && (out_tag_o == 0);

  // an empty-store beat is always the last one and carries zeros
  `ASSERT_AT(a_empty_beat, clk_i, rst_ni, (out_strobe_o && !out_valid_o) |-> empty_ok, "empty beat malformed")

  // a read keeps the block busy on the following cycle
  `ASSERT_AT(a_read_busy, clk_i, rst_ni, read_acc |=> busy, "read did not raise busy")

  // an insert produces no result beat
  `ASSERT_AT(a_ins_quiet, clk_i, rst_ni, ins_acc |=> !out_strobe_o, "insert produced a beat")

  // no register write while a read-out is running
  `ASSERT_NEVER(a_cfg_busy, clk_i, rst_ni, busy && cfg_ready_o, "config ready while busy")

endmodule

bind top_n_sorted_tracker_core tnst_checker u_tnst_checker (.*);
